FILE: rtl/core/quoted_printable_decoder_top_macros.svh
// Assertion macros for the quoted-printable decoder checker
`ifndef QUOTED_PRINTABLE_DECODER_TOP_MACROS_SVH
`define QUOTED_PRINTABLE_DECODER_TOP_MACROS_SVH

// same-cycle implication
`define QPD_ASSERT_NOW(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("qpd assertion failed");

// next-cycle implication
`define QPD_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("qpd assertion failed");

`endif

FILE: rtl/core/qpd_pkg.sv
// Package: constants, types and helper functions of the quoted-printable decoder
`timescale 1ns / 1ps
package qpd_pkg;

	localparam int WS_MAX  = 32;
	localparam int CNT_W   = $clog2(WS_MAX + 1);
	localparam int IDX_W   = $clog2(WS_MAX);
	localparam int LIT_MAX = 3;
	localparam int LIT_W   = 2;

	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(WS_MAX);

	localparam logic [7:0] CH_EQ    = 8'd61;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_TAB   = 8'd9;
	localparam logic [7:0] CH_SP    = 8'd32;
	localparam logic [7:0] CH_PR_LO = 8'd33;
	localparam logic [7:0] CH_PR_HI = 8'd126;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_CR    = 3'd1,
		PH_EQ    = 3'd2,
		PH_EQHEX = 3'd3,
		PH_EQCR  = 3'd4
	} qpd_phase_t;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'd0,
		ST_BLANK = 2'd1,
		ST_LIT   = 2'd2
	} qpd_state_t;

	typedef struct packed {
		logic accept;
		logic blank_step;
		logic lit_step;
	} qpd_cmd_t;

	typedef struct packed {
		logic plan_blank;
		logic plan_lit;
		logic blank_last;
		logic lit_last;
		logic lit_pend;
	} qpd_sts_t;

	function automatic logic is_hex(input logic [7:0] c);
		return c inside {[8'd48:8'd57], [8'd65:8'd70], [8'd97:8'd102]};
	endfunction

	function automatic logic [3:0] hex_val(input logic [7:0] c);
		logic [7:0] d;
		if (c inside {[8'd48:8'd57]}) begin
			d = c - 8'd48;
		end else if (c inside {[8'd65:8'd70]}) begin
			d = c - 8'd55;
		end else begin
			d = c - 8'd87;
		end
		return d[3:0];
	endfunction

endpackage

FILE: rtl/core/qpd_in_if.sv
// Interface: encoded byte request channel
`timescale 1ns / 1ps
interface qpd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_stream;

	modport source (output valid, output in_byte, output end_of_stream, input ready);
	modport sink (input valid, input in_byte, input end_of_stream, output ready);
endinterface

FILE: rtl/core/qpd_out_if.sv
// Interface: decoded byte request channel
`timescale 1ns / 1ps
interface qpd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last_of_run;

	modport source (output valid, output out_byte, output last_of_run, input ready);
	modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface

FILE: rtl/core/qpd_datapath.sv
// Datapath: decode state, held blanks, literal queue and output register
`timescale 1ns / 1ps
module qpd_datapath (
	input  logic             clk,
	input  logic             arst_n,
	input  qpd_pkg::qpd_cmd_t cmd,
	output qpd_pkg::qpd_sts_t sts,
	input  logic [7:0]       in_byte,
	input  logic             end_of_stream,
	output logic [7:0]       out_byte,
	output logic             last_of_run
);
	import qpd_pkg::*;

	qpd_phase_t       phase_q;
	logic [7:0]       fh_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] nb_q;
	logic [IDX_W-1:0] bidx_q;
	logic [7:0]       lits_q [LIT_MAX];
	logic [LIT_W-1:0] nl_q;
	logic [LIT_W-1:0] lidx_q;
	logic             wpend_q;
	logic             wkind_q;
	logic             kinds_q [WS_MAX];
	logic [7:0]       out_byte_q;
	logic             out_last_q;

	qpd_phase_t       ph_d;
	logic [7:0]       fh_d;
	logic [CNT_W-1:0] cnt_d;
	logic [CNT_W-1:0] nb_d;
	logic [7:0]       lits_d [LIT_MAX];
	logic [LIT_W-1:0] nl_d;
	logic             wr_d;
	logic             wkind_d;
	logic [IDX_W-1:0] widx_d;
	logic             run_idle;
	logic             blank_last;
	logic             lit_last;

	always_comb begin
		ph_d     = phase_q;
		fh_d     = fh_q;
		cnt_d    = cnt_q;
		nb_d     = '0;
		nl_d     = '0;
		wr_d     = 1'b0;
		wkind_d  = (in_byte == CH_TAB);
		widx_d   = '0;
		run_idle = 1'b0;
		for (int i = 0; i < LIT_MAX; i++) begin
			lits_d[i] = '0;
		end

		case (phase_q)
			PH_CR, PH_EQCR: begin
				ph_d     = PH_IDLE;
				run_idle = (in_byte != CH_LF);
			end
			PH_EQ: begin
				if (in_byte == CH_CR) begin
					ph_d = PH_EQCR;
				end else if (in_byte == CH_LF) begin
					ph_d = PH_IDLE;
				end else if (is_hex(in_byte)) begin
					fh_d = in_byte;
					ph_d = PH_EQHEX;
				end else begin
					lits_d[0] = CH_EQ;
					nl_d      = LIT_W'(1);
					ph_d      = PH_IDLE;
					run_idle  = 1'b1;
				end
			end
			PH_EQHEX: begin
				ph_d = PH_IDLE;
				if (is_hex(in_byte)) begin
					lits_d[0] = {hex_val(fh_q), hex_val(in_byte)};
					nl_d      = LIT_W'(1);
				end else begin
					lits_d[0] = CH_EQ;
					lits_d[1] = fh_q;
					nl_d      = LIT_W'(2);
					run_idle  = 1'b1;
				end
			end
			default: begin
				ph_d     = PH_IDLE;
				run_idle = 1'b1;
			end
		endcase

		if (run_idle) begin
			if (cnt_d >= CNT_FULL) begin
				nb_d  = cnt_d;
				cnt_d = '0;
			end
			if (in_byte == CH_EQ) begin
				if (cnt_d != '0) begin
					nb_d = cnt_d;
				end
				cnt_d = '0;
				ph_d  = PH_EQ;
			end else if (in_byte == CH_TAB || in_byte == CH_SP) begin
				if (cnt_d < CNT_FULL) begin
					wr_d   = 1'b1;
					widx_d = cnt_d[IDX_W-1:0];
					cnt_d  = cnt_d + CNT_W'(1);
				end
			end else if (in_byte >= CH_PR_LO && in_byte <= CH_PR_HI) begin
				if (cnt_d != '0) begin
					nb_d = cnt_d;
				end
				cnt_d        = '0;
				lits_d[nl_d] = in_byte;
				nl_d         = nl_d + LIT_W'(1);
			end else if (in_byte == CH_CR || in_byte == CH_LF) begin
				cnt_d        = '0;
				lits_d[nl_d] = CH_LF;
				nl_d         = nl_d + LIT_W'(1);
				ph_d         = (in_byte == CH_CR) ? PH_CR : PH_IDLE;
			end
		end

		if (end_of_stream) begin
			if (ph_d == PH_EQ) begin
				lits_d[nl_d] = CH_EQ;
				nl_d         = nl_d + LIT_W'(1);
			end else if (ph_d == PH_EQHEX) begin
				lits_d[nl_d]               = CH_EQ;
				lits_d[nl_d + LIT_W'(1)]   = fh_d;
				nl_d                       = nl_d + LIT_W'(2);
			end
			ph_d  = PH_IDLE;
			fh_d  = '0;
			cnt_d = '0;
		end
	end

	assign blank_last = (CNT_W'(bidx_q) == nb_q - CNT_W'(1));
	assign lit_last   = (lidx_q == nl_q - LIT_W'(1));

	always_comb begin
		sts.plan_blank = (nb_d != '0);
		sts.plan_lit   = (nl_d != '0);
		sts.blank_last = blank_last;
		sts.lit_last   = lit_last;
		sts.lit_pend   = (nl_q != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			fh_q    <= '0;
			cnt_q   <= '0;
			nb_q    <= '0;
			bidx_q  <= '0;
			nl_q    <= '0;
			lidx_q  <= '0;
			wpend_q <= 1'b0;
		end else begin
			if (cmd.accept) begin
				phase_q <= ph_d;
				fh_q    <= fh_d;
				cnt_q   <= cnt_d;
				nb_q    <= nb_d;
				bidx_q  <= '0;
				nl_q    <= nl_d;
				lidx_q  <= '0;
				wpend_q <= wr_d && (nb_d != '0);
			end
			if (cmd.blank_step) begin
				bidx_q <= bidx_q + IDX_W'(1);
				if (blank_last) begin
					wpend_q <= 1'b0;
				end
			end
			if (cmd.lit_step) begin
				lidx_q <= lidx_q + LIT_W'(1);
			end
		end
	end

	// blank kinds: written at accept, or after the flush that frees entry zero
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			lits_q  <= lits_d;
			wkind_q <= wkind_d;
		end
		if (cmd.accept && wr_d && (nb_d == '0)) begin
			kinds_q[widx_d] <= wkind_d;
		end else if (cmd.blank_step && blank_last && wpend_q) begin
			kinds_q[0] <= wkind_q;
		end
		if (cmd.blank_step) begin
			out_byte_q <= kinds_q[bidx_q] ? CH_TAB : CH_SP;
			out_last_q <= blank_last && (nl_q == '0);
		end else if (cmd.lit_step) begin
			out_byte_q <= lits_q[lidx_q];
			out_last_q <= lit_last;
		end
	end

	assign out_byte    = out_byte_q;
	assign last_of_run = out_last_q;
endmodule

FILE: rtl/core/qpd_ctrl.sv
// Controller: sequences held blanks and literal bytes into the output register
`timescale 1ns / 1ps
module qpd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  qpd_pkg::qpd_sts_t sts,
	output qpd_pkg::qpd_cmd_t cmd
);
	import qpd_pkg::*;

	qpd_state_t state_q;
	qpd_state_t state_d;
	logic       out_valid_q;
	logic       adv;

	assign adv = !out_valid_q || out_ready;

	always_comb begin
		state_d        = state_q;
		cmd.accept     = 1'b0;
		cmd.blank_step = 1'b0;
		cmd.lit_step   = 1'b0;
		in_ready       = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (sts.plan_blank) begin
						state_d = ST_BLANK;
					end else if (sts.plan_lit) begin
						state_d = ST_LIT;
					end
				end
			end
			ST_BLANK: begin
				if (adv) begin
					cmd.blank_step = 1'b1;
					if (sts.blank_last) begin
						state_d = sts.lit_pend ? ST_LIT : ST_IDLE;
					end
				end
			end
			ST_LIT: begin
				if (adv) begin
					cmd.lit_step = 1'b1;
					if (sts.lit_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.blank_step || cmd.lit_step) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
endmodule

FILE: rtl/core/quoted_printable_decoder_top.sv
// Quoted-printable decoder: one encoded byte in, zero to 33 decoded bytes out
// First results pass the controller state register, then the output register.
// The input is held while a request's results go out, one byte per cycle while the
// output is not stalled; a request giving none leaves the controller idle.
// Reset: arst_n clears decode phase, held-blank count and the output valid at once.
`timescale 1ns / 1ps
module quoted_printable_decoder_top (
	input logic       clk,
	input logic       arst_n,
	qpd_in_if.sink    enc_ch,
	qpd_out_if.source dec_ch
);
	import qpd_pkg::*;

	qpd_cmd_t cmd;
	qpd_sts_t sts;

	qpd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (enc_ch.valid),
		.in_ready  (enc_ch.ready),
		.out_valid (dec_ch.valid),
		.out_ready (dec_ch.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	qpd_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.in_byte       (enc_ch.in_byte),
		.end_of_stream (enc_ch.end_of_stream),
		.out_byte      (dec_ch.out_byte),
		.last_of_run   (dec_ch.last_of_run)
	);
endmodule

FILE: rtl/core/qpd_checker.sv
// Checker: port-level assertions for the quoted-printable decoder, bound to the top level
`timescale 1ns / 1ps
`include "quoted_printable_decoder_top_macros.svh"
module qpd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       last_of_run
);
	`QPD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
	`QPD_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_byte) && $stable(last_of_run))
	`QPD_ASSERT_NOW(a_no_take_mid_run, out_valid && !last_of_run, !in_ready)
	`QPD_ASSERT_NOW(a_busy_drives_out, !in_ready && $past(!in_ready), out_valid)
	`QPD_ASSERT_NEXT(a_run_continues, out_valid && out_ready && !last_of_run, out_valid)
endmodule

bind quoted_printable_decoder_top qpd_checker u_qpd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (enc_ch.ready),
	.out_valid   (dec_ch.valid),
	.out_ready   (dec_ch.ready),
	.out_byte    (dec_ch.out_byte),
	.last_of_run (dec_ch.last_of_run)
);
